@@ hdl/ctscan_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and character tables of the token scanner.
package ctscan_pkg;

    localparam int MAX_TEXT_LENGTH = 255;
    localparam int LEN_W = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_SEMI = ";";

    typedef enum logic [3:0] {
        KIND_LBRACE  = 4'd0,
        KIND_RBRACE  = 4'd1,
        KIND_LPAREN  = 4'd2,
        KIND_RPAREN  = 4'd3,
        KIND_SEMI    = 4'd4,
        KIND_INT     = 4'd5,
        KIND_RETURN  = 4'd6,
        KIND_MAIN    = 4'd7,
        KIND_INTEGER = 4'd8,
        KIND_NAME    = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NAME = 2'd1,
        MODE_NUM  = 2'd2
    } t_mode;

    localparam int KW_COUNT = 3;
    localparam logic [7:0] KW_CHARS [KW_COUNT][6] = '{
        '{"i", "n", "t", 8'd0, 8'd0, 8'd0},
        '{"r", "e", "t", "u", "r", "n"},
        '{"m", "a", "i", "n", 8'd0, 8'd0}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd6, 3'd4};
    localparam t_kind KW_KIND [KW_COUNT] = '{KIND_INT, KIND_RETURN, KIND_MAIN};

    typedef struct packed {
        t_kind       kind;
        logic [30:0] literal_value;
        logic        value_overflow;
        logic [31:0] text_start;
        logic [7:0]  text_length;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic   has_second;
        t_token tok0;
        t_token tok1;
    } t_pair;

endpackage

@@ hdl/ctscan_if.sv @@
`timescale 1ns / 1ps
// Handshake interfaces for source bytes and emitted tokens.
interface ctscan_byte_if import ctscan_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;

    modport source (output valid, output source_byte, output end_of_input, input ready);
    modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface ctscan_token_if import ctscan_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [30:0] literal_value;
    logic        value_overflow;
    logic [31:0] text_start;
    logic [7:0]  text_length;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output literal_value, output value_overflow,
        output text_start, output text_length, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input literal_value, input value_overflow,
        input text_start, input text_length, input last_of_run, output ready
    );
endinterface

@@ hdl/ctscan_front.sv @@
`timescale 1ns / 1ps
// Scanner front end: classifies each byte and forms the tokens it completes.
module ctscan_front import ctscan_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ctscan_byte_if.sink    i_byte,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output t_pair          o_push_data
);

    t_mode              r_mode, n_mode;
    logic [2:0]         r_mask, n_mask;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [30:0]        r_num, n_num;
    logic               r_ovf, n_ovf;
    logic [31:0]        r_start, n_start;
    logic [31:0]        r_pos, n_pos;

    logic [7:0]         b;
    logic               fire;
    logic               is_letter, is_digit, is_cont, is_punct;
    logic               used;
    logic               a_valid, c_valid;
    t_token             tok_a, tok_b, tok_c;
    t_kind              punct;
    logic [34:0]        product;

    function automatic logic [2:0] match_update(logic [2:0] mask, logic [LEN_W-1:0] idx,
                                                logic [7:0] ch);
        logic [2:0]         m;
        logic [LEN_W+7:0]   widx;
        m = mask;
        widx = {8'd0, idx};
        for (int k = 0; k < KW_COUNT; k++) begin
            if (widx >= (LEN_W + 8)'(KW_LEN[k])) begin
                m[k] = 1'b0;
            end else if (KW_CHARS[k][idx[2:0]] != ch) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [7:0] shown_length(logic [LEN_W-1:0] len);
        logic [LEN_W+7:0] wide;
        wide = {8'd0, len};
        if (wide > (LEN_W + 8)'(255)) begin
            return 8'hFF;
        end
        return wide[7:0];
    endfunction

    function automatic t_token flush_tok(t_mode mode, logic [2:0] mask, logic [LEN_W-1:0] len,
                                         logic [30:0] num, logic ovf, logic [31:0] start);
        t_token t;
        t.kind = KIND_NAME;
        t.literal_value = '0;
        t.value_overflow = 1'b0;
        t.text_start = start;
        t.text_length = shown_length(len);
        t.last_of_run = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (mask[k] && ({8'd0, len} == (LEN_W + 8)'(KW_LEN[k]))) begin
                t.kind = KW_KIND[k];
            end
        end
        if (mode == MODE_NUM) begin
            t.kind = KIND_INTEGER;
            t.literal_value = num;
            t.value_overflow = ovf;
        end
        return t;
    endfunction

    assign b = i_byte.source_byte;
    assign i_byte.ready = i_push_ready;
    assign fire = i_byte.valid && i_push_ready;
    assign product = ({1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0}) + {27'd0, b - CH_ZERO};

    always_comb begin
        is_letter = (b inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
        is_digit = (b inside {[CH_ZERO:CH_NINE]});
        is_cont = is_letter || is_digit || (b == CH_UNDERSCORE);
        is_punct = 1'b1;
        case (b)
            CH_LBRACE: punct = KIND_LBRACE;
            CH_RBRACE: punct = KIND_RBRACE;
            CH_LPAREN: punct = KIND_LPAREN;
            CH_RPAREN: punct = KIND_RPAREN;
            CH_SEMI:   punct = KIND_SEMI;
            default: begin
                punct = KIND_SEMI;
                is_punct = 1'b0;
            end
        endcase

        tok_a = flush_tok(r_mode, r_mask, r_len, r_num, r_ovf, r_start);
        used = ((r_mode == MODE_NAME) && is_cont) || ((r_mode == MODE_NUM) && is_digit);
        a_valid = (r_mode != MODE_IDLE) && !used;

        n_mode = r_mode;
        n_mask = r_mask;
        n_len = r_len;
        n_num = r_num;
        n_ovf = r_ovf;
        n_start = r_start;

        if (used) begin
            if (r_len < LEN_W'(MAX_TEXT_LENGTH)) begin
                n_len = r_len + 1'b1;
            end
            if (r_mode == MODE_NAME) begin
                n_mask = match_update(r_mask, r_len, b);
            end else if (product > {4'd0, VALUE_MAX}) begin
                n_num = VALUE_MAX;
                n_ovf = 1'b1;
            end else begin
                n_num = product[30:0];
            end
        end else begin
            n_mode = MODE_IDLE;
            n_mask = 3'b111;
            n_len = '0;
            n_num = '0;
            n_ovf = 1'b0;
            n_start = '0;
            if (is_letter) begin
                n_mode = MODE_NAME;
                n_mask = match_update(3'b111, '0, b);
                n_len = LEN_W'(1);
                n_start = r_pos;
            end else if (is_digit) begin
                n_mode = MODE_NUM;
                n_num = {23'd0, b - CH_ZERO};
                n_len = LEN_W'(1);
                n_start = r_pos;
            end
        end

        tok_b.kind = punct;
        tok_b.literal_value = '0;
        tok_b.value_overflow = 1'b0;
        tok_b.text_start = r_pos;
        tok_b.text_length = 8'd1;
        tok_b.last_of_run = 1'b0;

        tok_c = flush_tok(n_mode, n_mask, n_len, n_num, n_ovf, n_start);
        c_valid = i_byte.end_of_input && (n_mode != MODE_IDLE);

        n_pos = r_pos + 32'd1;
        if (i_byte.end_of_input) begin
            n_mode = MODE_IDLE;
            n_mask = 3'b111;
            n_len = '0;
            n_num = '0;
            n_ovf = 1'b0;
            n_start = '0;
            n_pos = '0;
        end

        o_push_data.has_second = a_valid && ((is_punct && !used) || c_valid);
        if (a_valid) begin
            o_push_data.tok0 = tok_a;
        end else if (is_punct && !used) begin
            o_push_data.tok0 = tok_b;
        end else begin
            o_push_data.tok0 = tok_c;
        end
        o_push_data.tok1 = c_valid ? tok_c : tok_b;
        o_push_data.tok0.last_of_run = !o_push_data.has_second;
        o_push_data.tok1.last_of_run = 1'b1;
        o_push_valid = fire && (a_valid || (is_punct && !used) || c_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_mask <= 3'b111;
            r_len <= '0;
            r_num <= '0;
            r_ovf <= 1'b0;
            r_start <= '0;
            r_pos <= '0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_mask <= n_mask;
            r_len <= n_len;
            r_num <= n_num;
            r_ovf <= n_ovf;
            r_start <= n_start;
            r_pos <= n_pos;
        end
    end

endmodule

@@ hdl/ctscan_queue.sv @@
`timescale 1ns / 1ps
// Small register queue of token pairs between the front end and the back end.
module ctscan_queue import ctscan_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_pair i_push_data,
    output logic  o_head_valid,
    output t_pair o_head_data,
    input  logic  i_pop
);

    t_pair              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               push, pop;

    assign o_push_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_data = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/ctscan_back.sv @@
`timescale 1ns / 1ps
// Scanner back end: splits token pairs and holds each token in the output register.
module ctscan_back import ctscan_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  t_pair           i_head_data,
    output logic            o_pop,
    ctscan_token_if.source  o_token
);

    logic   r_out_valid, n_out_valid;
    logic   r_idx, n_idx;
    t_token r_tok, n_tok;
    logic   load;

    always_comb begin
        load = i_head_valid && (!r_out_valid || o_token.ready);
        n_out_valid = r_out_valid && !o_token.ready;
        n_tok = r_tok;
        n_idx = r_idx;
        o_pop = 1'b0;
        if (load) begin
            n_out_valid = 1'b1;
            n_tok = r_idx ? i_head_data.tok1 : i_head_data.tok0;
            o_pop = r_idx || !i_head_data.has_second;
            n_idx = !r_idx && i_head_data.has_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_token.valid = r_out_valid;
    assign o_token.token_kind = r_tok.kind;
    assign o_token.literal_value = r_tok.literal_value;
    assign o_token.value_overflow = r_tok.value_overflow;
    assign o_token.text_start = r_tok.text_start;
    assign o_token.text_length = r_tok.text_length;
    assign o_token.last_of_run = r_tok.last_of_run;

endmodule

@@ hdl/c_subset_token_scanner.sv @@
`timescale 1ns / 1ps
// Top level of the byte-serial token scanner for a small C subset.
// The scanner takes one source byte per cycle while its queue has room and emits names,
// keywords, decimal integers and the marks { } ( ) ; as transactions on the token channel,
// each carrying its start position and saturated length. A byte yields zero, one or two
// tokens; the front end takes a byte every cycle as long as its four-entry pair queue has
// room, and the back end drains one token per cycle through its output register while the
// token port is ready, so the token port sets the sustained limit of one token per cycle.
// A byte with end_of_input set flushes any pending token and restarts byte positions at
// zero. Tokens enter the queue at the edge that accepts their byte, then the output register.
module c_subset_token_scanner import ctscan_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ctscan_byte_if.sink     i_byte,
    ctscan_token_if.source  o_token
);

    logic  push_valid, push_ready;
    t_pair push_data;
    logic  head_valid, pop;
    t_pair head_data;

    ctscan_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    ctscan_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_head_valid (head_valid),
        .o_head_data  (head_data),
        .i_pop        (pop)
    );

    ctscan_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_data  (head_data),
        .o_pop        (pop),
        .o_token      (o_token)
    );

`ifndef ASSERT_OFF
    a_push_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> push_ready)
        else $error("Token pair pushed while the queue was full.");

    a_literal_only_on_integer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_token.valid && (o_token.token_kind != KIND_INTEGER))
            |-> ((o_token.literal_value == '0) && !o_token.value_overflow))
        else $error("Literal value on a token that is not an integer.");

    a_pop_only_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (head_valid && $past(i_rst_n)))
        else $error("Queue popped while empty.");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_token.valid)
        else $error("Token valid right after reset.");
`endif

endmodule
